/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property must never hold at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ASSERT_HOLD(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

/* src/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg
// shared types and constants of the date string parser
// ----------------------------------------------------------------------------
package dsp_pkg;

  // accumulator and digit counter widths
  localparam int DayAccW   = 7;
  localparam int MonAccW   = 7;
  localparam int YearAccW  = 14;
  localparam int DigCntW   = 2;
  localparam int YearCntW  = 3;

  // result field widths
  localparam int DayW  = 5;
  localparam int MonW  = 4;
  localparam int YearW = 12;

  // character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // digit count limits
  localparam logic [DigCntW-1:0]  FieldMaxDigits = 2'd2;
  localparam logic [YearCntW-1:0] YearShortDigits = 3'd2;
  localparam logic [YearCntW-1:0] YearLongDigits  = 3'd4;

  // year and range limits
  localparam logic [YearAccW-1:0] YearPivot  = 14'd80;
  localparam logic [YearAccW-1:0] Century19  = 14'd1900;
  localparam logic [YearAccW-1:0] Century20  = 14'd2000;
  localparam logic [YearAccW-1:0] YearMin    = 14'd1980;
  localparam logic [YearAccW-1:0] YearMax    = 14'd2099;
  localparam logic [MonAccW-1:0]  MonthMax   = 7'd12;
  localparam logic [DayAccW-1:0]  DayMax     = 7'd31;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_FIELDS = 3'b010,
    PH_TRAIL  = 3'b100
  } phase_e;

  // field being collected
  typedef enum logic [1:0] {
    FLD_DAY   = 2'd0,
    FLD_MONTH = 2'd1,
    FLD_YEAR  = 2'd2
  } field_e;

  // parsed date word
  typedef struct packed {
    logic             date_valid;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } result_t;

endpackage

/* src/date_string_parser_top.sv */
// ----------------------------------------------------------------------------
// date_string_parser_top
// date string parser: one character word in, one date word per end marker
// ----------------------------------------------------------------------------
// path: an end marker passes the input register, then the result register,
//   before its result word shows on the output
// throughput: one word per cycle; an end marker waits in the input register
//   only while the result register holds an untaken word
// reset: clears parse state, input and output valid; payload is not reset
`include "assert_macros.svh"

module date_string_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_marker_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        date_valid_o,
  output logic [dsp_pkg::DayW-1:0]  day_value_o,
  output logic [dsp_pkg::MonW-1:0]  month_value_o,
  output logic [dsp_pkg::YearW-1:0] year_value_o
);

  logic             in_vld_q;
  logic [7:0]       char_q;
  logic             end_q;
  logic             adv;
  logic             out_vld_q;
  dsp_pkg::result_t res;
  dsp_pkg::result_t out_q;

  // held word moves on unless it is an end marker blocked by a full output
  assign adv        = in_vld_q && (!end_q || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
      end_q  <= end_marker_i;
    end
  end

  // parse state and date check
  dsp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .char_i   (char_q),
    .end_i    (end_q),
    .result_o (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && end_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && end_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign date_valid_o  = out_q.date_valid;
  assign day_value_o   = out_q.day;
  assign month_value_o = out_q.month;
  assign year_value_o  = out_q.year;

  // checks
  `ASSERT_HOLD(a_stall_only_end, clk_i, rst_ni, in_stall_o |-> (end_q && out_vld_q && out_stall_i), "input stalled without a blocked end marker")
  `ASSERT_HOLD(a_end_loads_out, clk_i, rst_ni, (adv && end_q) |=> out_valid_o, "end marker did not produce a result word")
  `ASSERT_HOLD(a_invalid_zero, clk_i, rst_ni, (out_valid_o && !date_valid_o) |-> (day_value_o == '0 && month_value_o == '0 && year_value_o == '0), "invalid date word not zeroed")
  `ASSERT_NEVER(a_valid_range, clk_i, rst_ni, out_valid_o && date_valid_o && (day_value_o == '0 || month_value_o == '0 || month_value_o > 4'd12 || year_value_o < 12'd1980 || year_value_o > 12'd2099), "valid date word out of range")

endmodule

/* src/dsp_core.sv */
// ----------------------------------------------------------------------------
// dsp_core
// parse state registers, per-character update and date check
// ----------------------------------------------------------------------------
module dsp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       char_i,
  input  logic             end_i,
  output dsp_pkg::result_t result_o
);

  dsp_pkg::phase_e phase_q, phase_d;
  dsp_pkg::field_e field_q, field_d;
  logic            err_q, err_d;
  logic [dsp_pkg::DayAccW-1:0]  day_acc_q, day_acc_d;
  logic [dsp_pkg::MonAccW-1:0]  mon_acc_q, mon_acc_d;
  logic [dsp_pkg::YearAccW-1:0] year_acc_q, year_acc_d;
  logic [dsp_pkg::DigCntW-1:0]  day_cnt_q, day_cnt_d;
  logic [dsp_pkg::DigCntW-1:0]  mon_cnt_q, mon_cnt_d;
  logic [dsp_pkg::YearCntW-1:0] year_cnt_q, year_cnt_d;

  logic       is_blank;
  logic       is_digit;
  logic       is_sep;
  logic [3:0] dig;
  logic       cur_empty;

  // character classes
  assign is_blank = (char_i == dsp_pkg::ChSpace) || (char_i == dsp_pkg::ChTab);
  assign is_digit = char_i inside {[dsp_pkg::ChZero:dsp_pkg::ChNine]};
  assign is_sep   = (char_i == dsp_pkg::ChSlash) || (char_i == dsp_pkg::ChDash);
  assign dig      = char_i[3:0];

  // no digits yet in the current field
  always_comb begin
    case (field_q)
      dsp_pkg::FLD_DAY:   cur_empty = (day_cnt_q == '0);
      dsp_pkg::FLD_MONTH: cur_empty = (mon_cnt_q == '0);
      default:            cur_empty = (year_cnt_q == '0);
    endcase
  end

  // next state for one character or end marker
  always_comb begin
    phase_d    = phase_q;
    field_d    = field_q;
    err_d      = err_q;
    day_acc_d  = day_acc_q;
    mon_acc_d  = mon_acc_q;
    year_acc_d = year_acc_q;
    day_cnt_d  = day_cnt_q;
    mon_cnt_d  = mon_cnt_q;
    year_cnt_d = year_cnt_q;
    if (end_i) begin
      phase_d    = dsp_pkg::PH_LEAD;
      field_d    = dsp_pkg::FLD_DAY;
      err_d      = 1'b0;
      day_acc_d  = '0;
      mon_acc_d  = '0;
      year_acc_d = '0;
      day_cnt_d  = '0;
      mon_cnt_d  = '0;
      year_cnt_d = '0;
    end else if (!err_q) begin
      if (phase_q == dsp_pkg::PH_TRAIL) begin
        if (!is_blank) err_d = 1'b1;
      end else if (!(phase_q == dsp_pkg::PH_LEAD && is_blank)) begin
        phase_d = dsp_pkg::PH_FIELDS;
        if (is_digit) begin
          case (field_q)
            dsp_pkg::FLD_DAY: begin
              if (day_cnt_q >= dsp_pkg::FieldMaxDigits) begin
                err_d = 1'b1;
              end else begin
                day_acc_d = day_acc_q * 7'd10 + {3'b000, dig};
                day_cnt_d = day_cnt_q + 2'd1;
              end
            end
            dsp_pkg::FLD_MONTH: begin
              if (mon_cnt_q >= dsp_pkg::FieldMaxDigits) begin
                err_d = 1'b1;
              end else begin
                mon_acc_d = mon_acc_q * 7'd10 + {3'b000, dig};
                mon_cnt_d = mon_cnt_q + 2'd1;
              end
            end
            default: begin
              if (year_cnt_q >= dsp_pkg::YearLongDigits) begin
                err_d = 1'b1;
              end else begin
                year_acc_d = year_acc_q * 14'd10 + {10'b0, dig};
                year_cnt_d = year_cnt_q + 3'd1;
              end
            end
          endcase
        end else if (is_sep) begin
          case (field_q)
            dsp_pkg::FLD_DAY:   field_d = dsp_pkg::FLD_MONTH;
            dsp_pkg::FLD_MONTH: field_d = dsp_pkg::FLD_YEAR;
            default:            field_d = field_q;
          endcase
          if (cur_empty || field_q == dsp_pkg::FLD_YEAR) begin
            err_d   = 1'b1;
            field_d = field_q;
          end
        end else if (is_blank) begin
          phase_d = dsp_pkg::PH_TRAIL;
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dsp_pkg::PH_LEAD;
      field_q    <= dsp_pkg::FLD_DAY;
      err_q      <= 1'b0;
      day_acc_q  <= '0;
      mon_acc_q  <= '0;
      year_acc_q <= '0;
      day_cnt_q  <= '0;
      mon_cnt_q  <= '0;
      year_cnt_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      field_q    <= field_d;
      err_q      <= err_d;
      day_acc_q  <= day_acc_d;
      mon_acc_q  <= mon_acc_d;
      year_acc_q <= year_acc_d;
      day_cnt_q  <= day_cnt_d;
      mon_cnt_q  <= mon_cnt_d;
      year_cnt_q <= year_cnt_d;
    end
  end

  logic [dsp_pkg::YearAccW-1:0] year_full;
  logic                         ok;

  // full year and range checks
  always_comb begin
    year_full = year_acc_q;
    if (year_cnt_q == dsp_pkg::YearShortDigits) begin
      year_full = (year_acc_q >= dsp_pkg::YearPivot) ? year_acc_q + dsp_pkg::Century19
                                                     : year_acc_q + dsp_pkg::Century20;
    end
    ok = !err_q && (field_q == dsp_pkg::FLD_YEAR)
         && (year_cnt_q == dsp_pkg::YearShortDigits || year_cnt_q == dsp_pkg::YearLongDigits)
         && (year_full >= dsp_pkg::YearMin) && (year_full <= dsp_pkg::YearMax)
         && (mon_acc_q != '0) && (mon_acc_q <= dsp_pkg::MonthMax)
         && (day_acc_q != '0) && (day_acc_q <= dsp_pkg::DayMax);
    result_o.date_valid = ok;
    result_o.day        = ok ? day_acc_q[dsp_pkg::DayW-1:0] : '0;
    result_o.month      = ok ? mon_acc_q[dsp_pkg::MonW-1:0] : '0;
    result_o.year       = ok ? year_full[dsp_pkg::YearW-1:0] : '0;
  end

endmodule
